// ===== hw/rtl/sobel_edge_magnitude_top_defines.svh =====
// Assertion macros shared by the queue and back-end RTL files.
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SEM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SEM_ASSERT_IMP(lbl, ante, cons)
`define SEM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/sbl_pkg.sv =====
`timescale 1ns / 1ps
package sbl_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int LUMA_W = 16;
    localparam int PIX_W = 24;
    localparam int COL_W = 10;
    localparam int ROW_W = 16;
    localparam int IMG_W_W = 11;
    localparam int CFG_W = 16;
    localparam int IDX_W = 2;
    localparam int GRAD_W = 20;
    localparam int SQ_W = 38;
    localparam int EMIT_W = 4;

    localparam logic [IDX_W-1:0] REG_WIDTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IMG_W_W-1:0] WIDTH_RST = 11'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RST = 16'd480;

    localparam logic [7:0] KR = 8'd77;
    localparam logic [7:0] KG = 8'd150;
    localparam logic [7:0] KB = 8'd29;

    // emission slots, in output order
    localparam int EM_MID = 0;
    localparam int EM_END = 1;
    localparam int EM_LMID = 2;
    localparam int EM_LEND = 3;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t [8:0]          win;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [EMIT_W-1:0]   emit;
    } job_t;

    typedef enum logic {
        F_IDLE,
        F_WORK
    } front_st_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAD,
        B_SQ,
        B_SUM,
        B_SQRT,
        B_OUT
    } back_st_t;
endpackage

// ===== hw/rtl/sbl_front.sv =====
`timescale 1ns / 1ps
module sbl_front #(
    parameter int MAX_WIDTH = sbl_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbl_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sbl_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    alpha,
    output logic                          q_push,
    input  logic                          q_ready,
    output sbl_pkg::job_t                 q_job
);
    import sbl_pkg::*;

    localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int XWP = XW + 1;

    pix_t line_above [MAX_WIDTH];
    pix_t line_two_above [MAX_WIDTH];

    front_st_t              st_reg, st_next;
    logic [IMG_W_W-1:0]     width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [XW-1:0]          col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [XW-1:0]          x_reg;
    logic [ROW_W-1:0]       y_reg;
    pix_t                   pix_reg;
    pix_t                   up1_reg;
    pix_t                   up2_reg;
    pix_t [8:0]             window_reg;
    pix_t [8:0]             window_next;

    logic [XWP-1:0]         eff_w;
    logic [ROW_W-1:0]       eff_h;
    logic [XW-1:0]          x_c;
    logic [LUMA_W-1:0]      luma_c;
    logic                   accept;
    logic                   cfg_hit;
    logic                   end_col;
    logic                   last_row;
    logic [EMIT_W-1:0]      emit;
    logic                   commit;
    pix_t                   nv [3];

    always_comb
    begin
        if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = XWP'(MAX_WIDTH);
        else if (width_reg < 11'd2)
            eff_w = XWP'(2);
        else
            eff_w = XWP'(width_reg);
        eff_h = (height_reg < 16'd2) ? 16'd2 : height_reg;
        if ({1'b0, col_reg} >= eff_w)
            x_c = XW'(eff_w - XWP'(1));
        else
            x_c = col_reg;
        luma_c = LUMA_W'(KR) * LUMA_W'(red) + LUMA_W'(KG) * LUMA_W'(green)
               + LUMA_W'(KB) * LUMA_W'(blue);
    end

    always_comb
    begin
        end_col  = ({1'b0, x_reg} == eff_w - XWP'(1));
        last_row = (y_reg >= eff_h - 16'd1);
        emit = '0;
        if (y_reg != '0)
        begin
            emit[EM_MID]  = (x_reg != '0);
            emit[EM_END]  = end_col;
            emit[EM_LMID] = last_row && (x_reg != '0);
            emit[EM_LEND] = last_row && end_col;
        end
        nv[0] = up2_reg;
        nv[1] = up1_reg;
        nv[2] = pix_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (x_reg == '0)
            begin
                window_next[i*3+0] = nv[i];
                window_next[i*3+1] = nv[i];
            end
            else
            begin
                window_next[i*3+0] = window_reg[i*3+1];
                window_next[i*3+1] = window_reg[i*3+2];
            end
            window_next[i*3+2] = nv[i];
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE:
                if (in_valid)
                    st_next = F_WORK;
            F_WORK:
                if (emit == '0 || q_ready)
                    st_next = F_IDLE;
            default:
                st_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        q_push    = 1'b0;
        commit    = 1'b0;
        cfg_ready = 1'b1;
        case (st_reg)
            F_IDLE:
                in_ready = 1'b1;
            F_WORK:
            begin
                q_push = (emit != '0) && q_ready;
                commit = (emit == '0) || q_ready;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    assign accept  = in_valid && in_ready;
    assign cfg_hit = cfg_valid && cfg_ready
                   && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    assign q_job.win  = window_next;
    assign q_job.col  = COL_W'(x_reg);
    assign q_job.row  = y_reg;
    assign q_job.emit = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= F_IDLE;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            window_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (commit)
            begin
                window_reg <= window_next;
                if (end_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : y_reg + 16'd1;
                end
                else
                begin
                    col_reg <= x_reg + XW'(1);
                end
            end
            // restart the frame on a width or height register write
            if (cfg_hit)
            begin
                col_reg <= '0;
                row_reg <= '0;
                if (cfg_index == REG_WIDTH)
                    width_reg <= cfg_data[IMG_W_W-1:0];
                else
                    height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= x_c;
            y_reg   <= row_reg;
            pix_reg <= {alpha, luma_c};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up1_reg <= line_above[x_c];
            up2_reg <= line_two_above[x_c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            line_above[x_reg]     <= pix_reg;
            line_two_above[x_reg] <= up1_reg;
        end
    end
endmodule

// ===== hw/rtl/sbl_queue.sv =====
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_top_defines.svh"
module sbl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           push_ready,
    input  sbl_pkg::job_t  push_job,
    output logic           pop_valid,
    input  logic           pop,
    output sbl_pkg::job_t  pop_job
);
    import sbl_pkg::*;

    job_t       mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    `SEM_ASSERT_IMP(a_no_overflow, push, count_reg != 2'd2)
    `SEM_ASSERT_IMP(a_no_underflow, pop, count_reg != 2'd0)
    `SEM_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 2'd1)
endmodule

// ===== hw/rtl/sbl_back.sv =====
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_top_defines.svh"
module sbl_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  sbl_pkg::job_t                q_job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   edge_res,
    output logic [7:0]                   alpha_out,
    output logic [sbl_pkg::COL_W-1:0]    out_col,
    output logic [sbl_pkg::ROW_W-1:0]    out_row,
    output logic                         last
);
    import sbl_pkg::*;

    back_st_t                  st_reg, st_next;
    job_t                      job_reg;
    logic [EMIT_W-1:0]         pend_reg;
    logic signed [GRAD_W-1:0]  gx_reg, gy_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [SQ_W-1:0]           rem_reg, res_reg, bit_reg;
    logic [7:0]                alpha_reg;
    logic [COL_W-1:0]          col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic                      last_reg;

    logic [EMIT_W-1:0]         cur;
    logic                      is_end, is_lrow;
    logic [1:0]                r [3];
    logic [1:0]                c [3];
    logic [LUMA_W-1:0]         lm [3][3];
    logic [3:0]                aidx;
    logic [GRAD_W-1:0]         px, nx, py, ny;
    logic signed [2*GRAD_W-1:0] pxx, pyy;
    logic [SQ_W-1:0]           trial;

    always_comb
    begin
        cur     = pend_reg & (~pend_reg + EMIT_W'(1));
        is_end  = cur[EM_END] || cur[EM_LEND];
        is_lrow = cur[EM_LMID] || cur[EM_LEND];
        if (is_lrow)
        begin
            r[0] = 2'd1;
            r[1] = 2'd2;
        end
        else
        begin
            r[0] = (job_reg.row == 16'd1) ? 2'd1 : 2'd0;
            r[1] = 2'd1;
        end
        r[2] = 2'd2;
        c[0] = is_end ? 2'd1 : 2'd0;
        c[1] = is_end ? 2'd2 : 2'd1;
        c[2] = 2'd2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                lm[i][j] = job_reg.win[4'(r[i]) * 4'd3 + 4'(c[j])][LUMA_W-1:0];
        aidx = 4'(r[1]) * 4'd3 + 4'(c[1]);
        px = GRAD_W'(lm[0][2]) + (GRAD_W'(lm[1][2]) << 1) + GRAD_W'(lm[2][2]);
        nx = GRAD_W'(lm[0][0]) + (GRAD_W'(lm[1][0]) << 1) + GRAD_W'(lm[2][0]);
        py = GRAD_W'(lm[2][0]) + (GRAD_W'(lm[2][1]) << 1) + GRAD_W'(lm[2][2]);
        ny = GRAD_W'(lm[0][0]) + (GRAD_W'(lm[0][1]) << 1) + GRAD_W'(lm[0][2]);
        pxx = gx_reg * gx_reg;
        pyy = gy_reg * gy_reg;
        trial = res_reg + bit_reg;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE:
                if (q_valid)
                    st_next = B_GRAD;
            B_GRAD:
                st_next = B_SQ;
            B_SQ:
                st_next = B_SUM;
            B_SUM:
                st_next = B_SQRT;
            B_SQRT:
                if (bit_reg[0])
                    st_next = B_OUT;
            B_OUT:
                if (out_ready)
                    st_next = ((pend_reg & ~cur) != '0) ? B_GRAD : B_IDLE;
            default:
                st_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
        case (st_reg)
            B_IDLE:
                q_pop = q_valid;
            B_OUT:
                out_valid = 1'b1;
            default:
                out_valid = 1'b0;
        endcase
    end

    assign edge_res  = (res_reg[SQ_W-1:16] != '0) ? 8'd255 : res_reg[15:8];
    assign alpha_out = alpha_reg;
    assign out_col   = col_reg;
    assign out_row   = row_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            pend_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (q_pop)
                pend_reg <= q_job.emit;
            else if (st_reg == B_OUT && out_ready)
                pend_reg <= pend_reg & ~cur;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
                if (q_pop)
                    job_reg <= q_job;
            B_GRAD:
            begin
                gx_reg    <= $signed(px - nx);
                gy_reg    <= $signed(py - ny);
                alpha_reg <= job_reg.win[aidx][PIX_W-1:LUMA_W];
                col_reg   <= is_end ? job_reg.col : job_reg.col - COL_W'(1);
                row_reg   <= is_lrow ? job_reg.row : job_reg.row - ROW_W'(1);
                last_reg  <= ((pend_reg & ~cur) == '0);
            end
            B_SQ:
            begin
                sqx_reg <= pxx[SQ_W-1:0];
                sqy_reg <= pyy[SQ_W-1:0];
            end
            B_SUM:
            begin
                rem_reg <= sqx_reg + sqy_reg;
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
            end
            B_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
                job_reg <= job_reg;
        endcase
    end

    `SEM_ASSERT_IMP(a_sqrt_onehot, st_reg == B_SQRT, $onehot(bit_reg))
    `SEM_ASSERT_IMP(a_out_pending, st_reg == B_OUT, pend_reg != '0)
    `SEM_ASSERT_IMP(a_last_single, st_reg == B_OUT && last_reg, $onehot(pend_reg))
endmodule

// ===== hw/rtl/sobel_edge_magnitude_top.sv =====
`timescale 1ns / 1ps
// 3x3 Sobel edge magnitude over an RGBA raster stream.
// Pixel channel: in_valid/in_ready with red, green, blue, alpha, raster order.
// Result channel: out_valid/out_ready with edge_res, alpha_out, out_col,
// out_row and last; last marks the final result caused by one pixel.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 = width, 1 = height;
// always ready, write only while idle; a width or height write restarts the frame at (0,0).
// Results for row y-1 follow pixel (x,y); the last row is also flushed.
// The front takes a new pixel only after the last one is committed (line buffer read, then update).
// The back computes each result in turn: gradient, squares, sum,
// then a 19-step bit-pair square root; that unit sets the result rate.
// A two-entry job queue sits between front and back.
// With the back idle, a pixel's first result goes through the front's work
// state, the job queue and the back's gradient, square, sum and root states.
// Reset sets width 640, height 480 and zeroes counters and window; line
// buffers are not cleared. A stalled receiver holds the result register,
// the queue fills, and then in_ready drops.
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH = sbl_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbl_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sbl_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    alpha,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    edge_res,
    output logic [7:0]                    alpha_out,
    output logic [sbl_pkg::COL_W-1:0]     out_col,
    output logic [sbl_pkg::ROW_W-1:0]     out_row,
    output logic                          last
);
    import sbl_pkg::*;

    logic  q_push, q_ready, q_valid, q_pop;
    job_t  push_job, pop_job;

    sbl_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .q_push    (q_push),
        .q_ready   (q_ready),
        .q_job     (push_job)
    );

    sbl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_ready),
        .push_job   (push_job),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_job    (pop_job)
    );

    sbl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_job     (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .edge_res  (edge_res),
        .alpha_out (alpha_out),
        .out_col   (out_col),
        .out_row   (out_row),
        .last      (last)
    );
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import sbl_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd2;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [7:0]       magnitude;
        logic [7:0]       alpha;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             lst;
    } edge_pix_t;

    class edge_scoreboard;
        edge_pix_t        expected_q[$];
        int               errors;
        logic [IMG_W_W-1:0] img_w;
        logic [ROW_W-1:0] img_h;
        logic [PIX_W-1:0] above[MAX_WIDTH_DEF];
        logic [PIX_W-1:0] two_above[MAX_WIDTH_DEF];
        logic [PIX_W-1:0] win[9];
        int unsigned      col_cnt;
        int unsigned      row_cnt;

        function new();
            img_w = WIDTH_RST;
            img_h = HEIGHT_RST;
            errors = 0;
            col_cnt = 0;
            row_cnt = 0;
            foreach (above[i])
            begin
                above[i] = '0;
                two_above[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_WIDTH)
                img_w = data[IMG_W_W-1:0];
            else if (idx == REG_HEIGHT)
                img_h = data;
            else
                return;
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function edge_pix_t gradient(int r[3], int c[3], int unsigned col, int unsigned row);
            longint lum[3][3];
            longint gx;
            longint gy;
            longint unsigned mag;
            edge_pix_t e;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    lum[i][j] = longint'(win[r[i] * 3 + c[j]][LUMA_W-1:0]);
            gx = (lum[0][2] + 2 * lum[1][2] + lum[2][2]) - (lum[0][0] + 2 * lum[1][0] + lum[2][0]);
            gy = (lum[2][0] + 2 * lum[2][1] + lum[2][2]) - (lum[0][0] + 2 * lum[0][1] + lum[0][2]);
            mag = floor_sqrt(longint'(gx * gx + gy * gy)) >> 8;
            if (mag > 255)
                mag = 255;
            e.magnitude = 8'(mag);
            e.alpha = win[r[1] * 3 + c[1]][23:16];
            e.col = COL_W'(col);
            e.row = ROW_W'(row);
            e.lst = 1'b0;
            return e;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            logic [LUMA_W-1:0] luma;
            logic [PIX_W-1:0] pix;
            logic [PIX_W-1:0] up1;
            logic [PIX_W-1:0] up2;
            logic [PIX_W-1:0] nv;
            bit end_col;
            edge_pix_t step_q[$];
            w = (img_w < 2) ? 2 : ((img_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : img_w);
            h = (img_h < 2) ? 2 : img_h;
            x = col_cnt;
            y = row_cnt;
            if (x >= w)
                x = w - 1;
            luma = LUMA_W'(77 * int'(r) + 150 * int'(g) + 29 * int'(b));
            pix = {a, luma};
            up1 = above[x];
            up2 = two_above[x];
            two_above[x] = up1;
            above[x] = pix;
            for (int i = 0; i < 3; i++)
            begin
                nv = (i == 0) ? up2 : ((i == 1) ? up1 : pix);
                if (x == 0)
                begin
                    win[i * 3] = nv;
                    win[i * 3 + 1] = nv;
                end
                else
                begin
                    win[i * 3] = win[i * 3 + 1];
                    win[i * 3 + 1] = win[i * 3 + 2];
                end
                win[i * 3 + 2] = nv;
            end
            end_col = (x >= w - 1);
            if (y >= 1)
            begin
                if (x >= 1)
                    step_q.push_back(gradient('{(y == 1) ? 1 : 0, 1, 2}, '{0, 1, 2}, x - 1, y - 1));
                if (end_col)
                    step_q.push_back(gradient('{(y == 1) ? 1 : 0, 1, 2}, '{1, 2, 2}, x, y - 1));
                if (y >= h - 1)
                begin
                    if (x >= 1)
                        step_q.push_back(gradient('{1, 2, 2}, '{0, 1, 2}, x - 1, y));
                    if (end_col)
                        step_q.push_back(gradient('{1, 2, 2}, '{1, 2, 2}, x, y));
                end
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].lst = 1'b1;
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
            if (end_col)
            begin
                col_cnt = 0;
                row_cnt = (y >= h - 1) ? 0 : ((y + 1) & 32'hFFFF);
            end
            else
                col_cnt = x + 1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(edge_pix_t got);
            edge_pix_t exp_pix;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected item col %0d row %0d", got.col, got.row));
                return;
            end
            exp_pix = expected_q.pop_front();
            if (got.magnitude !== exp_pix.magnitude)
                report($sformatf("edge_res %0d, want %0d at (%0d,%0d)", got.magnitude,
                    exp_pix.magnitude, exp_pix.col, exp_pix.row));
            if (got.alpha !== exp_pix.alpha)
                report($sformatf("alpha_out %0d, want %0d", got.alpha, exp_pix.alpha));
            if (got.col !== exp_pix.col)
                report($sformatf("out_col %0d, want %0d", got.col, exp_pix.col));
            if (got.row !== exp_pix.row)
                report($sformatf("out_row %0d, want %0d", got.row, exp_pix.row));
            if (got.lst !== exp_pix.lst)
                report($sformatf("last %0d, want %0d", got.lst, exp_pix.lst));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       edge_res;
    logic [7:0]       alpha_out;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             last;

    edge_scoreboard sb;
    int burst_left = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int unsigned cycle_cnt = 0;

    sobel_edge_magnitude_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .edge_res  (edge_res),
        .alpha_out (alpha_out),
        .out_col   (out_col),
        .out_row   (out_row),
        .last      (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin : result_side
        edge_pix_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.magnitude = edge_res;
            got.alpha = alpha_out;
            got.col = out_col;
            got.row = out_row;
            got.lst = last;
            sb.check_result(got);
        end
        cycle_cnt++;
        if (cycle_cnt % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (cycle_cnt % 8 < 5);
            endcase
    end

    function logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        alpha <= a;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(r, g, b, a);
        burst_left--;
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    task send_random(int n);
        repeat (n)
            send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel());
    endtask

    // drop valid, then hold until every item is back and the pipe is empty
    task wait_idle();
        if (burst_left > 0)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int w;
        int h;
        int n;
        int rand_sent;
        int frame_no;
        logic [7:0] v;
        sb = new();
        rst_n = 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        red <= '0;
        green <= '0;
        blue <= '0;
        alpha <= '0;
        out_ready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out-of-range sizes clamp to a 2x2 frame
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        wait_idle();

        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++)
        begin
            v = (((i % 2) ^ ((i / 3) % 2)) != 0) ? 8'd255 : 8'd0;
            send_pixel(v, v, v, 8'(i * 28));
        end
        wait_idle();

        write_reg(REG_UNUSED, 16'hFFFF);
        send_random(9);
        wait_idle();

        write_reg(REG_WIDTH, 16'hFFFF);
        write_reg(REG_HEIGHT, 16'hFFFF);
        send_random(6);
        wait_idle();

        write_reg(REG_WIDTH, 16'd1024);
        write_reg(REG_HEIGHT, 16'd2);
        send_random(16);
        wait_idle();

        rand_sent = 0;
        frame_no = 0;
        while (rand_sent < 320)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 6);
            h = $urandom_range(2, 5);
            if (frame_no == 0)
            begin
                w = 40;
                h = 4;
            end
            wait_idle();
            write_reg(REG_WIDTH, 16'(w));
            write_reg(REG_HEIGHT, 16'(h));
            n = w * h;
            if (frame_no == 0)
                hold_req = 1;
            else if ($urandom_range(0, 5) == 0)
                n = $urandom_range(1, n);
            else if ($urandom_range(0, 5) == 0)
                n = 2 * w * h;
            if (n > 320 - rand_sent)
                n = 320 - rand_sent;
            send_random(n);
            rand_sent += n;
            frame_no++;
        end
        wait_idle();

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sbl_pkg.sv
hw/rtl/sbl_front.sv
hw/rtl/sbl_queue.sv
hw/rtl/sbl_back.sv
hw/rtl/sobel_edge_magnitude_top.sv
tb/sv/testbench.sv
